### rtl/rsrg_pkg.sv
// Shared types and constants for the replacement-selection run generator.
package rsrg_pkg;

    localparam int KEY_W = 31;
    localparam int TAG_W = 16;
    localparam int RUN_W = 16;
    localparam int CFG_W = 4;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(5);
    localparam logic [RUN_W-1:0] RUN_MAX   = {RUN_W{1'b1}};

    typedef struct packed {
        logic             is_flush;
        logic [KEY_W-1:0] key;
        logic [TAG_W-1:0] tag;
    } t_in;

    typedef struct packed {
        logic [KEY_W-1:0] out_key;
        logic [TAG_W-1:0] out_tag;
        logic [RUN_W-1:0] run_number;
        logic             first_of_run;
        logic             last;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_LAST,
        ST_DECIDE,
        ST_EMIT,
        ST_POST,
        ST_CLEAR
    } t_state;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_step;
        logic select;
        logic fill;
        logic emit;
        logic post;
        logic clear;
    } t_cmd;

    typedef struct packed {
        logic is_flush;
        logic last_issue;
        logic has_free;
        logic any_valid;
        logic out_free;
        logic flush_last;
    } t_sts;

endpackage

### rtl/replacement_selection_run_gen.sv
// Top level of the replacement-selection run generator.
//
// This block forms sorted runs for an external sort by replacement selection. Records (key and
// tag) first fill a reservoir whose size is set by the configuration register (zero acts as one,
// values above RESERVOIR_DEPTH act as the depth). Once it is full, every record emits the
// smallest unfrozen key, the lowest slot winning ties, and takes that slot; it is frozen when its
// key is below the key just emitted. When all slots in use are frozen they are thawed and a new
// run begins, flagged by first_of_run; the run number saturates at its maximum. A flush beat
// drains the reservoir in run order, flags its final result with last, and clears the block,
// while the size register keeps its value. Items are handled one at a time. Each item is taken and
// then the slot store is scanned serially through its single read port, one slot per cycle. A
// record then fills a free slot if there is one; else the selected slot is emitted and replaced,
// and a new run opens if every slot in use is now frozen. A flush emits one drained record per
// scan, scanning again after each, and then clears the block, also when the reservoir is
// empty. An emitted result sits in an output register, so the next input beat is taken while it
// waits; a further emission waits for that register to be freed. No clearing pass is needed after
// reset: the slot store is gated by valid bits.
module replacement_selection_run_gen #(
    parameter int RESERVOIR_DEPTH = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rsrg_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  rsrg_pkg::t_in               i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output rsrg_pkg::t_out              o_out_data
);

    rsrg_pkg::t_cmd cmd;
    rsrg_pkg::t_sts sts;

    // The controller sequences the scan, the decision and the emission of each item.
    rsrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // The datapath holds the slots, the valid and frozen bits, and the run state.
    rsrg_dp #(
        .DEPTH (RESERVOIR_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

### rtl/rsrg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module rsrg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/rsrg_ctrl.sv
// Sequencing state machine of the run generator.
module rsrg_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  rsrg_pkg::t_sts  i_sts,
    output rsrg_pkg::t_cmd  o_cmd
);

    rsrg_pkg::t_state r_state;
    rsrg_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsrg_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            rsrg_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load       = 1'b1;
                    o_cmd.scan_start = 1'b1;
                    n_state          = rsrg_pkg::ST_SCAN;
                end
            end
            rsrg_pkg::ST_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_sts.last_issue) begin
                    n_state = rsrg_pkg::ST_SCAN_LAST;
                end
            end
            rsrg_pkg::ST_SCAN_LAST: begin
                n_state = rsrg_pkg::ST_DECIDE;
            end
            rsrg_pkg::ST_DECIDE: begin
                if (i_sts.is_flush) begin
                    if (i_sts.any_valid) begin
                        o_cmd.select = 1'b1;
                        n_state      = rsrg_pkg::ST_EMIT;
                    end else begin
                        n_state = rsrg_pkg::ST_CLEAR;
                    end
                end else if (i_sts.has_free) begin
                    o_cmd.fill = 1'b1;
                    n_state    = rsrg_pkg::ST_IDLE;
                end else begin
                    o_cmd.select = 1'b1;
                    n_state      = rsrg_pkg::ST_EMIT;
                end
            end
            rsrg_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_sts.is_flush) begin
                        n_state = rsrg_pkg::ST_POST;
                    end else if (i_sts.flush_last) begin
                        n_state = rsrg_pkg::ST_CLEAR;
                    end else begin
                        o_cmd.scan_start = 1'b1;
                        n_state          = rsrg_pkg::ST_SCAN;
                    end
                end
            end
            rsrg_pkg::ST_POST: begin
                o_cmd.post = 1'b1;
                n_state    = rsrg_pkg::ST_IDLE;
            end
            rsrg_pkg::ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                n_state     = rsrg_pkg::ST_IDLE;
            end
            default: begin
                n_state = rsrg_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/rsrg_dp.sv
// Datapath of the run generator: slot store, serial minimum scan and run state.
module rsrg_dp #(
    parameter int DEPTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [rsrg_pkg::CFG_W-1:0]     i_cfg_data,
    input  rsrg_pkg::t_in                  i_in_data,
    input  rsrg_pkg::t_cmd                 i_cmd,
    output rsrg_pkg::t_sts                 o_sts,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output rsrg_pkg::t_out                 o_out_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);
    localparam int EW = (NW > rsrg_pkg::CFG_W) ? NW : rsrg_pkg::CFG_W;
    localparam int KW = rsrg_pkg::KEY_W;
    localparam int TW = rsrg_pkg::TAG_W;

    logic [rsrg_pkg::CFG_W-1:0] r_cfg;
    rsrg_pkg::t_in              r_item;
    logic [DEPTH-1:0]           r_valid;
    logic [DEPTH-1:0]           r_frozen;
    logic [KW-1:0]              r_lek;
    logic [rsrg_pkg::RUN_W-1:0] r_run;
    logic                       r_started;

    logic [AW-1:0] r_idx;
    logic          r_cmp_vld;
    logic [AW-1:0] r_cmp_idx;

    logic          r_umin_found;
    logic [KW-1:0] r_umin_key;
    logic [TW-1:0] r_umin_tag;
    logic [AW-1:0] r_umin_idx;
    logic          r_amin_found;
    logic [KW-1:0] r_amin_key;
    logic [TW-1:0] r_amin_tag;
    logic [AW-1:0] r_amin_idx;
    logic          r_free_found;
    logic [AW-1:0] r_free_idx;

    logic [AW-1:0] r_sel_idx;
    logic [KW-1:0] r_sel_key;
    logic [TW-1:0] r_sel_tag;

    logic           r_out_valid;
    rsrg_pkg::t_out r_out;

    logic [EW-1:0]      cfg_ext;
    logic [NW-1:0]      eff_n;
    logic [NW-1:0]      eff_n_m1;
    logic [DEPTH-1:0]   inuse;
    logic [DEPTH-1:0]   sel_bit;
    logic               out_free;
    logic               flush_last;
    logic               post_new_run;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [KW+TW-1:0]   ram_rdata;
    logic [KW-1:0]      rd_key;
    logic [TW-1:0]      rd_tag;

    // Effective size: zero acts as one, anything above the depth as the depth.
    always_comb begin
        cfg_ext = EW'(r_cfg);
        if (cfg_ext == '0) begin
            eff_n = NW'(1);
        end else if (cfg_ext > EW'(DEPTH)) begin
            eff_n = NW'(DEPTH);
        end else begin
            eff_n = NW'(cfg_ext);
        end
        eff_n_m1 = eff_n - NW'(1);
        for (int i = 0; i < DEPTH; i++) begin
            inuse[i]   = (NW'(i) < eff_n);
            sel_bit[i] = (AW'(i) == r_sel_idx);
        end
    end

    assign out_free     = !r_out_valid || i_out_ready;
    assign flush_last   = ((r_valid & inuse & ~sel_bit) == '0);
    assign post_new_run = ((r_valid & inuse) != '0) && ((r_valid & inuse & ~r_frozen) == '0);

    assign ram_we    = i_cmd.fill || (i_cmd.emit && !r_item.is_flush);
    assign ram_waddr = i_cmd.fill ? r_free_idx : r_sel_idx;
    assign rd_key    = ram_rdata[KW+TW-1:TW];
    assign rd_tag    = ram_rdata[TW-1:0];

    rsrg_ram #(
        .WIDTH (KW + TW),
        .DEPTH (DEPTH)
    ) u_slots (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({r_item.key, r_item.tag}),
        .i_raddr (r_idx),
        .o_rdata (ram_rdata)
    );

    // Control state and run bookkeeping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg        <= rsrg_pkg::CFG_RESET;
            r_valid      <= '0;
            r_frozen     <= '0;
            r_lek        <= '0;
            r_run        <= '0;
            r_started    <= 1'b0;
            r_idx        <= '0;
            r_cmp_vld    <= 1'b0;
            r_umin_found <= 1'b0;
            r_amin_found <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end

            if (i_cmd.scan_step) begin
                r_idx     <= r_idx + AW'(1);
                r_cmp_vld <= 1'b1;
            end else begin
                r_cmp_vld <= 1'b0;
            end

            if (i_cmd.scan_start) begin
                r_idx        <= '0;
                r_umin_found <= 1'b0;
                r_amin_found <= 1'b0;
                r_free_found <= 1'b0;
            end else if (r_cmp_vld) begin
                if (r_valid[r_cmp_idx]) begin
                    if (!r_amin_found || rd_key < r_amin_key) begin
                        r_amin_found <= 1'b1;
                    end
                    if (!r_frozen[r_cmp_idx] && (!r_umin_found || rd_key < r_umin_key)) begin
                        r_umin_found <= 1'b1;
                    end
                end else if (!r_free_found) begin
                    r_free_found <= 1'b1;
                end
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.clear) begin
                r_valid   <= '0;
                r_frozen  <= '0;
                r_lek     <= '0;
                r_run     <= '0;
                r_started <= 1'b0;
            end else if (i_cmd.select) begin
                // Every valid slot in use is frozen: open a new run.
                if (!r_umin_found && r_amin_found) begin
                    r_frozen  <= '0;
                    r_started <= 1'b0;
                    if (r_run != rsrg_pkg::RUN_MAX) begin
                        r_run <= r_run + rsrg_pkg::RUN_W'(1);
                    end
                end
            end else if (i_cmd.fill) begin
                r_valid[r_free_idx]  <= 1'b1;
                r_frozen[r_free_idx] <= r_started && (r_item.key < r_lek);
            end else if (i_cmd.emit) begin
                r_started <= 1'b1;
                r_lek     <= r_sel_key;
                if (r_item.is_flush) begin
                    r_valid[r_sel_idx]  <= 1'b0;
                    r_frozen[r_sel_idx] <= 1'b0;
                end else begin
                    r_frozen[r_sel_idx] <= (r_item.key < r_sel_key);
                end
            end else if (i_cmd.post) begin
                if (post_new_run) begin
                    r_frozen  <= '0;
                    r_started <= 1'b0;
                    if (r_run != rsrg_pkg::RUN_MAX) begin
                        r_run <= r_run + rsrg_pkg::RUN_W'(1);
                    end
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_data;
        end
        if (i_cmd.scan_step) begin
            r_cmp_idx <= r_idx;
        end
        if (!i_cmd.scan_start && r_cmp_vld) begin
            if (r_valid[r_cmp_idx]) begin
                if (!r_amin_found || rd_key < r_amin_key) begin
                    r_amin_key <= rd_key;
                    r_amin_tag <= rd_tag;
                    r_amin_idx <= r_cmp_idx;
                end
                if (!r_frozen[r_cmp_idx] && (!r_umin_found || rd_key < r_umin_key)) begin
                    r_umin_key <= rd_key;
                    r_umin_tag <= rd_tag;
                    r_umin_idx <= r_cmp_idx;
                end
            end else if (!r_free_found) begin
                r_free_idx <= r_cmp_idx;
            end
        end
        if (i_cmd.select) begin
            if (r_umin_found) begin
                r_sel_idx <= r_umin_idx;
                r_sel_key <= r_umin_key;
                r_sel_tag <= r_umin_tag;
            end else begin
                r_sel_idx <= r_amin_idx;
                r_sel_key <= r_amin_key;
                r_sel_tag <= r_amin_tag;
            end
        end
        if (i_cmd.emit) begin
            r_out.out_key      <= r_sel_key;
            r_out.out_tag      <= r_sel_tag;
            r_out.run_number   <= r_run;
            r_out.first_of_run <= !r_started;
            r_out.last         <= r_item.is_flush && flush_last;
        end
    end

    assign o_sts.is_flush   = r_item.is_flush;
    assign o_sts.last_issue = (r_idx == eff_n_m1[AW-1:0]);
    assign o_sts.has_free   = r_free_found;
    assign o_sts.any_valid  = r_amin_found;
    assign o_sts.out_free   = out_free;
    assign o_sts.flush_last = flush_last;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### test/rsrg_run_checker.sv
// Checker for the replacement-selection run generator: predicts every result beat and compares.
`timescale 1ns / 100ps
module rsrg_run_checker #(
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rsrg_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  rsrg_pkg::t_in              i_in_data,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  rsrg_pkg::t_out             i_out_data,
    output int                         o_mismatches,
    output int                         o_pending,
    output int                         o_results
);

    // Only the first mismatches are printed so that a broken block cannot flood the log.
    localparam int PRINT_CAP = 100;

    logic [rsrg_pkg::KEY_W-1:0] slot_key_m [DEPTH];
    logic [rsrg_pkg::TAG_W-1:0] slot_tag_m [DEPTH];
    logic [DEPTH-1:0]           valid_m;
    logic [DEPTH-1:0]           frozen_m;
    logic [rsrg_pkg::KEY_W-1:0] last_key_m;
    logic [rsrg_pkg::RUN_W-1:0] run_m;
    logic                       run_open_m;
    logic [rsrg_pkg::CFG_W-1:0] size_reg_m;

    rsrg_pkg::t_out due_records [$];
    int   errors  = 0;
    int   results = 0;

    function automatic int slots_in_use();
        int n;
        n = int'(size_reg_m);
        if (n < 1) n = 1;
        if (n > DEPTH) n = DEPTH;
        return n;
    endfunction

    // A new run opens when every valid slot in use is frozen.
    function automatic void thaw_if_all_frozen(int n);
        logic [DEPTH-1:0] in_use;
        in_use = '0;
        for (int i = 0; i < n; i++) in_use[i] = 1'b1;
        if ((valid_m & in_use) != '0 && (valid_m & in_use & ~frozen_m) == '0) begin
            frozen_m = '0;
            if (run_m != rsrg_pkg::RUN_MAX) run_m = run_m + 1'b1;
            run_open_m = 1'b0;
        end
    endfunction

    function automatic int lowest_min_slot(int n);
        int best;
        best = -1;
        for (int i = 0; i < n; i++) begin
            if (valid_m[i] && !frozen_m[i]) begin
                if (best < 0 || slot_key_m[i] < slot_key_m[best]) best = i;
            end
        end
        return best;
    endfunction

    function automatic void emit_slot(int s);
        rsrg_pkg::t_out r;
        r.out_key      = slot_key_m[s];
        r.out_tag      = slot_tag_m[s];
        r.run_number   = run_m;
        r.first_of_run = !run_open_m;
        r.last         = 1'b0;
        due_records.push_back(r);
        run_open_m = 1'b1;
        last_key_m = slot_key_m[s];
    endfunction

    function automatic void predict_beat(rsrg_pkg::t_in b);
        int             n;
        int             s;
        int             drained;
        rsrg_pkg::t_out tail;
        n = slots_in_use();
        drained = 0;
        if (b.is_flush) begin
            do begin
                thaw_if_all_frozen(n);
                s = lowest_min_slot(n);
                if (s >= 0) begin
                    emit_slot(s);
                    valid_m[s]  = 1'b0;
                    frozen_m[s] = 1'b0;
                    drained++;
                end
            end while (s >= 0);
            if (drained > 0) begin
                tail = due_records.pop_back();
                tail.last = 1'b1;
                due_records.push_back(tail);
            end
            valid_m    = '0;
            frozen_m   = '0;
            last_key_m = '0;
            run_m      = '0;
            run_open_m = 1'b0;
        end else begin
            for (int i = 0; i < n; i++) begin
                if (!valid_m[i]) begin
                    slot_key_m[i] = b.key;
                    slot_tag_m[i] = b.tag;
                    valid_m[i]    = 1'b1;
                    frozen_m[i]   = run_open_m && (b.key < last_key_m);
                    return;
                end
            end
            thaw_if_all_frozen(n);
            s = lowest_min_slot(n);
            if (s >= 0) begin
                emit_slot(s);
                slot_key_m[s] = b.key;
                slot_tag_m[s] = b.tag;
                frozen_m[s]   = (b.key < last_key_m);
                thaw_if_all_frozen(n);
            end
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (errors < PRINT_CAP) $display("MISMATCH at %0t ns: %s", $time, msg);
        errors++;
    endtask

    task automatic check_result(input rsrg_pkg::t_out got);
        rsrg_pkg::t_out want;
        results++;
        if (due_records.size() == 0) begin
            report_mismatch($sformatf("result beat %0d (key %h tag %h) with nothing due",
                                      results, got.out_key, got.out_tag));
        end else begin
            want = due_records.pop_front();
            if (got.out_key !== want.out_key)
                report_mismatch($sformatf("result %0d out_key %h, expected %h",
                                          results, got.out_key, want.out_key));
            if (got.out_tag !== want.out_tag)
                report_mismatch($sformatf("result %0d out_tag %h, expected %h",
                                          results, got.out_tag, want.out_tag));
            if (got.run_number !== want.run_number)
                report_mismatch($sformatf("result %0d run_number %0d, expected %0d",
                                          results, got.run_number, want.run_number));
            if (got.first_of_run !== want.first_of_run)
                report_mismatch($sformatf("result %0d first_of_run %b, expected %b",
                                          results, got.first_of_run, want.first_of_run));
            if (got.last !== want.last)
                report_mismatch($sformatf("result %0d last %b, expected %b",
                                          results, got.last, want.last));
        end
    endtask

    // Results are compared before the input of the same edge is predicted: a result can never
    // belong to a beat taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            valid_m    = '0;
            frozen_m   = '0;
            last_key_m = '0;
            run_m      = '0;
            run_open_m = 1'b0;
            size_reg_m = rsrg_pkg::CFG_RESET;
            due_records.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_result(i_out_data);
            if (i_cfg_we) size_reg_m = i_cfg_data;
            if (i_in_valid && i_in_ready) predict_beat(i_in_data);
        end
        o_pending    <= due_records.size();
        o_mismatches <= errors;
        o_results    <= results;
    end

endmodule

### test/replacement_selection_run_gen_tb.sv
// Testbench top for the replacement-selection run generator: stimulus, pacing and verdict.
`timescale 1ns / 100ps
module replacement_selection_run_gen_tb;

    localparam int DEPTH           = 8;
    // The limit is meant to cover a correct run with every flush draining a full reservoir under the
    // longest stalls.
    localparam int LIMIT_CYCLES    = 200_000;
    // Cycles allowed after the last result for a fill or a clear still in progress to finish.
    localparam int SETTLE_CYCLES   = 40;
    localparam int DRAIN_CYCLES    = 50;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_PHASES   = 8;
    localparam int BEATS_PER_PHASE = 43;

    localparam logic [rsrg_pkg::KEY_W-1:0] KEY_TOP = {rsrg_pkg::KEY_W{1'b1}};
    localparam logic [rsrg_pkg::TAG_W-1:0] TAG_TOP = {rsrg_pkg::TAG_W{1'b1}};

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [rsrg_pkg::CFG_W-1:0] cfg_data  = '0;
    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    rsrg_pkg::t_in              in_data   = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    rsrg_pkg::t_out             out_data;

    int mismatches;
    int pending;
    int results;
    int cycles       = 0;
    int beats_sent   = 0;
    int flushes_sent = 0;
    int size_writes  = 0;

    // When steady is set neither side idles; hold_req asks the receiver for one long hold-off.
    bit steady   = 1'b0;
    bit hold_req = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    replacement_selection_run_gen #(
        .RESERVOIR_DEPTH (DEPTH)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    rsrg_run_checker #(
        .DEPTH (DEPTH)
    ) u_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_data   (cfg_data),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results)
    );

    // Offers one beat after a random gap and returns at the edge that takes it. Valid is left
    // high, so a following beat with no gap is offered at once and taken when the block is ready.
    task automatic send_beat(input logic drain, input logic [rsrg_pkg::KEY_W-1:0] k,
                             input logic [rsrg_pkg::TAG_W-1:0] t);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{is_flush: drain, key: k, tag: t};
        do @(posedge clk); while (!in_ready);
        beats_sent++;
        if (drain) flushes_sent++;
    endtask

    // The size register is only written with the block idle: the sender stops, every due
    // result has been taken, and a fill or a clear that gives no result has had time to end.
    task automatic set_size(input logic [rsrg_pkg::CFG_W-1:0] v);
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we   <= 1'b0;
        size_writes++;
    endtask

    // Mostly records, with keys drawn so that ties, freezes and the extremes turn up often, and
    // now and then a flush carrying random junk in its ignored fields.
    task automatic send_random_beat();
        int                         pick;
        logic [rsrg_pkg::KEY_W-1:0] k;
        pick = $urandom_range(0, 99);
        if (pick < 40)      k = rsrg_pkg::KEY_W'($urandom);
        else if (pick < 80) k = rsrg_pkg::KEY_W'($urandom_range(0, 20));
        else if (pick < 90) k = '0;
        else                k = KEY_TOP;
        send_beat($urandom_range(0, 99) < 5, k, rsrg_pkg::TAG_W'($urandom));
    endtask

    // The receiver draws a gap before every result beat and, once asked, holds off for a long
    // stretch so that the output register fills and the block stops taking input.
    initial begin : receiver
        int gap;
        forever begin
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            gap = steady ? 0 : $urandom_range(0, 3);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
        end
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        while (cycles < LIMIT_CYCLES) begin
            @(posedge clk);
            cycles++;
        end
        $display("Timed out after %0d cycles with %0d results still due", cycles, pending);
        $display("replacement_selection_run_gen test failed");
        $finish;
    end

    initial begin : stimulus
        logic [rsrg_pkg::CFG_W-1:0] phase_sizes [RANDOM_PHASES];
        logic [rsrg_pkg::CFG_W-1:0] sz;
        phase_sizes = '{4'd8, 4'd15, 4'd1, 4'd3, 4'd0, 4'd8, 4'd6, 4'd12};

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, starting at the size the register holds after reset.
        // A flush of an empty reservoir gives nothing but still clears the block.
        send_beat(1'b1, KEY_TOP, TAG_TOP);
        // Fill five slots with both key extremes and a tie on key 100, the lowest slot winning.
        send_beat(1'b0, 31'd100, 16'd1);
        send_beat(1'b0, KEY_TOP, TAG_TOP);
        send_beat(1'b0, 31'd100, 16'd2);
        send_beat(1'b0, '0, '0);
        send_beat(1'b0, 31'd50, 16'd3);
        // Replacements: the first stays in the run, the next two are frozen.
        send_beat(1'b0, 31'd20, 16'd4);
        send_beat(1'b0, 31'd10, 16'd5);
        send_beat(1'b0, 31'd5, 16'd6);
        send_beat(1'b1, KEY_TOP, TAG_TOP);

        // A size of zero behaves as one: every falling key starts a new run.
        set_size(4'd0);
        send_beat(1'b0, 31'd7, 16'd7);
        send_beat(1'b0, 31'd3, 16'd8);
        send_beat(1'b0, 31'd9, 16'd9);
        send_beat(1'b1, '0, '0);

        // Open a run at size two, then grow the reservoir while loaded so that the new free
        // slots are filled during an open run, one of them frozen.
        set_size(4'd2);
        send_beat(1'b0, 31'd40, 16'd10);
        send_beat(1'b0, 31'd60, 16'd11);
        send_beat(1'b0, 31'd50, 16'd12);
        set_size(4'd4);
        send_beat(1'b0, 31'd10, 16'd13);
        send_beat(1'b0, 31'd45, 16'd14);
        // Shrink while loaded: slots above the new size are passed over, and the flush
        // throws them away.
        set_size(4'd1);
        send_beat(1'b0, 31'd30, 16'd15);
        send_beat(1'b1, KEY_TOP, TAG_TOP);

        // Random phases over a spread of sizes. Some phases end without a flush so that the
        // next size change meets a loaded reservoir; two run with no idling on either side.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sz = (p == RANDOM_PHASES - 1) ? rsrg_pkg::CFG_W'($urandom_range(0, 15))
                                          : phase_sizes[p];
            set_size(sz);
            steady = (p == 2 || p == 5);
            if (p == 3) hold_req = 1'b1;
            for (int i = 0; i < BEATS_PER_PHASE; i++) send_random_beat();
            if (p % 3 != 1)
                send_beat(1'b1, rsrg_pkg::KEY_W'($urandom), rsrg_pkg::TAG_W'($urandom));
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d input beats (%0d flushes) and %0d result beats over %0d size writes.",
                 beats_sent, flushes_sent, results, size_writes);
        $display("Sizes included zero, one, eight and fifteen, with one long output stall.");
        if (mismatches == 0 && pending == 0) begin
            $display("replacement_selection_run_gen test passed");
        end else begin
            $display("%0d mismatches, %0d results still due", mismatches, pending);
            $display("replacement_selection_run_gen test failed");
        end
        $finish;
    end

endmodule
